// File: rtl/core/salru_pkg.sv
// ----------------------------------------------------------------------------
// salru_pkg
// Operation codes, register indexes, controller states and fixed widths of
// the set-associative LRU cache tracker.
// ----------------------------------------------------------------------------
package salru_pkg;

  localparam int ADDR_W  = 64;
  localparam int TOTAL_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2,
    OP_OTHER  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_BITS   = 2'd0,
    REG_WAYS       = 2'd1,
    REG_BLOCK_BITS = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR  = 2'd0,
    ST_IDLE   = 2'd1,
    ST_LOOKUP = 2'd2
  } state_t;

  localparam logic [2:0] SET_BITS_RST   = 3'd4;
  localparam logic [3:0] WAYS_RST       = 4'd1;
  localparam logic [5:0] BLOCK_BITS_RST = 6'd4;

endpackage

// File: rtl/core/set_assoc_cache_lru_sim.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim
// Tag-only set-associative cache tracker with per-way LRU age ranks and
// saturating hit, miss and eviction totals.
// ----------------------------------------------------------------------------
// For a load, store or modify item the set row is read from the tag and
// status memories on the accepting edge, compared and updated during the
// next cycle, and written back at its end, where the result registers load.
// The strobe done is high in the cycle after that, while the block may already
// take the next item. An "other" item is taken and gives no result. After
// reset the block sweeps the status memory, one set per cycle, through every
// set with busy high. Results cannot be held off: the strobe done marks each
// one for exactly one cycle. Configuration writes are always taken.
module set_assoc_cache_lru_sim #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        operation,
  input  logic [salru_pkg::ADDR_W-1:0]      address,
  output logic                              done,
  output logic                              hit,
  output logic                              miss,
  output logic                              evicted,
  output logic                              second_hit,
  output logic [salru_pkg::TOTAL_W-1:0]     hit_total,
  output logic [salru_pkg::TOTAL_W-1:0]     miss_total,
  output logic [salru_pkg::TOTAL_W-1:0]     eviction_total,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [salru_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [salru_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int SW    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int DEPTH = 1 << MAX_SET_BITS;
  localparam int AW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WIW   = AW;
  localparam int NWW   = $clog2(MAX_WAYS + 1);
  localparam int AW64  = salru_pkg::ADDR_W;
  localparam int TW    = salru_pkg::TOTAL_W;
  localparam logic [SW-1:0] LAST_SET = SW'(DEPTH - 1);
  localparam logic [AW-1:0] AGE_MAX  = AW'(MAX_WAYS - 1);

  // Configuration registers
  logic [2:0] cfg_set_bits;
  logic [3:0] cfg_ways;
  logic [5:0] cfg_block_bits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_set_bits   <= salru_pkg::SET_BITS_RST;
      cfg_ways       <= salru_pkg::WAYS_RST;
      cfg_block_bits <= salru_pkg::BLOCK_BITS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (salru_pkg::reg_idx_t'(cfg_index))
        salru_pkg::REG_SET_BITS:   cfg_set_bits   <= cfg_data[2:0];
        salru_pkg::REG_WAYS:       cfg_ways       <= cfg_data[3:0];
        salru_pkg::REG_BLOCK_BITS: cfg_block_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective geometry
  logic [2:0]     sb;
  logic [NWW-1:0] nw;
  logic [SW-1:0]  set_mask;
  logic [6:0]     tag_shift;

  always_comb begin
    sb = (int'(cfg_set_bits) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : cfg_set_bits;
    if (cfg_ways == 4'd0) begin
      nw = NWW'(1);
    end else if (int'(cfg_ways) > MAX_WAYS) begin
      nw = NWW'(MAX_WAYS);
    end else begin
      nw = NWW'(cfg_ways);
    end
    for (int i = 0; i < SW; i++) begin
      set_mask[i] = (i < int'(sb));
    end
    tag_shift = {1'b0, cfg_block_bits} + {4'd0, sb};
  end

  // Set index and tag of the item at the input
  logic [AW64-1:0] addr_shifted;
  logic [SW-1:0]   set_in;
  logic [AW64-1:0] tag_in;

  always_comb begin
    addr_shifted = address >> cfg_block_bits;
    set_in       = addr_shifted[SW-1:0] & set_mask;
    tag_in       = (tag_shift >= 7'd64) ? '0 : (address >> tag_shift[5:0]);
  end

  // Control
  salru_pkg::state_t state, state_next;
  logic              accept;
  logic              accept_op;
  logic [SW-1:0]     clr_cnt;
  logic [SW-1:0]     set_q;
  logic [AW64-1:0]   tag_q;
  logic              modify_q;
  logic              meta_we;
  logic              tag_we;
  logic [SW-1:0]     wr_addr;

  assign accept    = start && !busy;
  assign accept_op = accept && (salru_pkg::op_t'(operation) != salru_pkg::OP_OTHER);

  always_comb begin
    state_next = state;
    case (state)
      salru_pkg::ST_CLEAR: begin
        if (clr_cnt == LAST_SET) state_next = salru_pkg::ST_IDLE;
      end
      salru_pkg::ST_IDLE: begin
        if (accept_op) state_next = salru_pkg::ST_LOOKUP;
      end
      salru_pkg::ST_LOOKUP: state_next = salru_pkg::ST_IDLE;
      default: state_next = salru_pkg::ST_CLEAR;
    endcase
  end

  logic lookup_miss;

  always_comb begin
    busy    = 1'b1;
    meta_we = 1'b0;
    tag_we  = 1'b0;
    wr_addr = set_q;
    case (state)
      salru_pkg::ST_CLEAR: begin
        meta_we = 1'b1;
        wr_addr = clr_cnt;
      end
      salru_pkg::ST_IDLE: busy = 1'b0;
      salru_pkg::ST_LOOKUP: begin
        meta_we = 1'b1;
        tag_we  = lookup_miss;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= salru_pkg::ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == salru_pkg::ST_CLEAR) clr_cnt <= clr_cnt + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept_op) begin
      set_q    <= set_in;
      tag_q    <= tag_in;
      modify_q <= (salru_pkg::op_t'(operation) == salru_pkg::OP_MODIFY);
    end
  end

  // Set memories: one row per set, every way side by side
  logic [MAX_WAYS-1:0][AW64-1:0] tag_mem [DEPTH];
  logic [MAX_WAYS-1:0][AW:0]     meta_mem [DEPTH];
  logic [MAX_WAYS-1:0][AW64-1:0] tag_rd, tag_wr;
  logic [MAX_WAYS-1:0][AW:0]     meta_rd, meta_wr, meta_upd;

  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[wr_addr] <= tag_wr;
    if (accept_op) tag_rd <= tag_mem[set_in];
  end

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[wr_addr] <= meta_wr;
    if (accept_op) meta_rd <= meta_mem[set_in];
  end

  assign meta_wr = (state == salru_pkg::ST_CLEAR) ? '0 : meta_upd;

  // Lookup, victim choice and age update
  logic [MAX_WAYS-1:0] in_use, vld, match, invalid;
  logic [MAX_WAYS-1:0][AW-1:0] age;
  logic                lookup_hit;
  logic                found_inv;
  logic                lookup_evict;
  logic [WIW-1:0]      hit_way, inv_way, lru_way, way_sel;
  logic [AW-1:0]       best_age;
  logic [AW-1:0]       limit_age;
  logic                limit_none;

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      in_use[i]  = (i < int'(nw));
      vld[i]     = meta_rd[i][AW];
      age[i]     = meta_rd[i][AW-1:0];
      match[i]   = in_use[i] && vld[i] && (tag_rd[i] == tag_q);
      invalid[i] = in_use[i] && !vld[i];
    end

    lookup_hit = 1'b0;
    hit_way    = '0;
    found_inv  = 1'b0;
    inv_way    = '0;
    lru_way    = '0;
    best_age   = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (!lookup_hit && match[i]) begin
        lookup_hit = 1'b1;
        hit_way    = WIW'(i);
      end
      if (!found_inv && invalid[i]) begin
        found_inv = 1'b1;
        inv_way   = WIW'(i);
      end
      // first way with the greatest age wins
      if (in_use[i] && (i == 0 || age[i] > best_age)) begin
        best_age = age[i];
        lru_way  = WIW'(i);
      end
    end

    lookup_miss  = !lookup_hit;
    lookup_evict = !lookup_hit && !found_inv;
    if (lookup_hit) begin
      way_sel = hit_way;
    end else if (found_inv) begin
      way_sel = inv_way;
    end else begin
      way_sel = lru_way;
    end
    limit_none = !lookup_hit && found_inv;
    limit_age  = age[way_sel];

    // Advance younger valid lines, then make the chosen way the newest
    meta_upd = meta_rd;
    tag_wr   = tag_rd;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (in_use[i] && WIW'(i) != way_sel && vld[i] &&
          (limit_none || age[i] < limit_age) && age[i] < AGE_MAX) begin
        meta_upd[i][AW-1:0] = age[i] + AW'(1);
      end
      if (WIW'(i) == way_sel) begin
        meta_upd[i] = {1'b1, {AW{1'b0}}};
        tag_wr[i]   = tag_q;
      end
    end
  end

  // Totals and result registers
  logic [TW:0]   hit_sum;
  logic [TW-1:0] hits_kept, misses_kept, evictions_kept;

  always_comb begin
    hit_sum = {1'b0, hits_kept} + (TW+1)'(lookup_hit) + (TW+1)'(modify_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hits_kept      <= '0;
      misses_kept    <= '0;
      evictions_kept <= '0;
      done           <= 1'b0;
    end else begin
      done <= (state == salru_pkg::ST_LOOKUP);
      if (state == salru_pkg::ST_LOOKUP) begin
        hits_kept <= hit_sum[TW] ? '1 : hit_sum[TW-1:0];
        if (lookup_miss && !(&misses_kept)) misses_kept <= misses_kept + TW'(1);
        if (lookup_evict && !(&evictions_kept)) begin
          evictions_kept <= evictions_kept + TW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == salru_pkg::ST_LOOKUP) begin
      hit        <= lookup_hit;
      miss       <= lookup_miss;
      evicted    <= lookup_evict;
      second_hit <= modify_q;
    end
  end

  assign hit_total      = hits_kept;
  assign miss_total     = misses_kept;
  assign eviction_total = evictions_kept;

  // Checks
  a_hit_xor_miss: assert property (@(posedge clk) disable iff (rst)
    done |-> (hit ^ miss))
    else $error("result is not exactly one of hit and miss");

  a_evict_on_miss: assert property (@(posedge clk) disable iff (rst)
    (done && evicted) |-> miss)
    else $error("eviction without a miss");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept_op |=> (busy && !done))
    else $error("block not busy after taking an item");

  a_done_after_lookup: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == salru_pkg::ST_LOOKUP))
    else $error("result strobe without a lookup");

endmodule
